[sv/ptt_pkg.sv]
package ptt_pkg;

    localparam int TAG_W       = 8;
    localparam int IVL_W       = 16;
    localparam int TIME_W      = 16;
    localparam int FUNC_W      = 3;
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 1;

    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam int MAX_RESULTS         = 16;
    localparam int N_W                 = $clog2(MAX_RESULTS + 1);

    localparam logic [CFG_W-1:0] INTERVAL_MIN_RESET = 16'd1;
    localparam logic [CFG_W-1:0] INTERVAL_MAX_RESET = 16'hFFFF;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL_MIN = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL_MAX = 1'b1;

    // result kinds
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FIRED = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ATTACH  = 3'd0,
        FUNC_START   = 3'd1,
        FUNC_STOP    = 3'd2,
        FUNC_ENABLE  = 3'd3,
        FUNC_DISABLE = 3'd4,
        FUNC_TICK    = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EX,
        ST_ADD,
        ST_REPLY,
        ST_FLUSH
    } state_t;

    // one table slot as stored in the memory
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [IVL_W-1:0]  interval;
        logic [TIME_W-1:0] stamp;
        logic              enabled;
    } entry_t;

    // flags from the shared compare unit
    typedef struct packed {
        logic tag_hit;
        logic due;
        logic bounds_ok;
    } unit_res_t;

endpackage

[sv/ptt_if.sv]
interface ptt_in_if;
    logic                          valid;
    logic                          ready;
    logic [ptt_pkg::FUNC_W-1:0]    func;
    logic [ptt_pkg::TAG_W-1:0]     tag;
    logic [ptt_pkg::IVL_W-1:0]     interval;
    logic                          enable_at_attach;
    logic [ptt_pkg::TIME_W-1:0]    now;

    modport source (output valid, func, tag, interval, enable_at_attach, now, input ready);
    modport sink   (input valid, func, tag, interval, enable_at_attach, now, output ready);
endinterface

interface ptt_out_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic                          ok;
    logic [ptt_pkg::TAG_W-1:0]     fired_tag;
    logic                          last;

    modport source (output valid, kind, ok, fired_tag, last, input ready);
    modport sink   (input valid, kind, ok, fired_tag, last, output ready);
endinterface

[sv/ptt_table.sv]
module ptt_table #(
    parameter int TABLE_DEPTH = ptt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic              clk,
    input  logic [IDX_W-1:0]  rd_addr,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  ptt_pkg::entry_t   wr_data,
    output ptt_pkg::entry_t   rd_data
);
    import ptt_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/ptt_unit.sv]
module ptt_unit (
    input  ptt_pkg::entry_t                 entry,
    input  logic [ptt_pkg::TAG_W-1:0]       cmd_tag,
    input  logic [ptt_pkg::IVL_W-1:0]       cmd_interval,
    input  logic [ptt_pkg::TIME_W-1:0]      now,
    input  logic [ptt_pkg::CFG_W-1:0]       interval_min,
    input  logic [ptt_pkg::CFG_W-1:0]       interval_max,
    output ptt_pkg::unit_res_t              res
);
    import ptt_pkg::*;

    logic [TIME_W-1:0] elapsed;

    // elapsed time wraps at the width of the time stamp
    assign elapsed = now - entry.stamp;

    always_comb
    begin
        res.tag_hit   = (entry.tag == cmd_tag);
        res.due       = (elapsed >= entry.interval);
        res.bounds_ok = (cmd_interval >= interval_min) && (cmd_interval <= interval_max);
    end

endmodule

[sv/periodic_timer_table.sv]
// periodic timer table
// in_ch takes one command word (attach, start all, stop all, enable one,
// disable one, tick); in_ch.ready is high only while the sequencer is idle.
// out_ch gives reply and fired words through one output register; last marks
// the final word caused by a command. Commands 0 to 4 and unused codes give
// one reply, a tick gives one word per fired timer (up to MAX_RESULTS) or none.
// The table sits in a memory with one registered read port, so every slot
// visited is first read, then compared and updated in the shared unit.
// Stop and unused codes go straight to the reply; start all, and a tick while
// running, visit every attached timer; attach, enable and disable search for
// the tag and stop at a hit, and attach adds a slot if the tag is not found.
// The number of attached timers is 16 at most by default (TABLE_DEPTH).
// A stalled receiver holds the output register; a tick scan waits on a slot
// that fires while an earlier fired word is still waiting to leave.
// Reset empties the table, clears the run flag and restores interval_min to 1
// and interval_max to 65535; configuration writes are taken at any time.
module periodic_timer_table #(
    parameter int TABLE_DEPTH = ptt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ptt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ptt_pkg::CFG_W-1:0]       cfg_wdata,
    ptt_in_if.sink                          in_ch,
    ptt_out_if.source                       out_ch
);
    import ptt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = IDX_W + 1;

    // configuration
    logic [CFG_W-1:0] interval_min_reg;
    logic [CFG_W-1:0] interval_max_reg;

    // sequencer state
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             running_reg, running_next;
    logic [N_W-1:0]   n_reg, n_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [TAG_W-1:0] pend_tag_reg, pend_tag_next;
    logic             ok_reg, ok_next;

    // latched command
    func_t             cmd_func_reg, cmd_func_next;
    logic [TAG_W-1:0]  cmd_tag_reg, cmd_tag_next;
    logic [IVL_W-1:0]  cmd_interval_reg, cmd_interval_next;
    logic              cmd_en_reg, cmd_en_next;
    logic [TIME_W-1:0] cmd_now_reg, cmd_now_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic             out_kind_reg, out_kind_next;
    logic             out_ok_reg, out_ok_next;
    logic [TAG_W-1:0] out_tag_reg, out_tag_next;
    logic             out_last_reg, out_last_next;

    // memory and unit signals
    entry_t           rd_entry;
    entry_t           wr_entry;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    unit_res_t        ures;

    logic             out_free;
    logic             last_slot;
    logic [CNT_W-1:0] idx_inc;

    ptt_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .clk     (clk),
        .rd_addr (idx_reg),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_data (rd_entry)
    );

    ptt_unit u_unit (
        .entry        (rd_entry),
        .cmd_tag      (cmd_tag_reg),
        .cmd_interval (cmd_interval_reg),
        .now          (cmd_now_reg),
        .interval_min (interval_min_reg),
        .interval_max (interval_max_reg),
        .res          (ures)
    );

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign idx_inc   = {1'b0, idx_reg} + CNT_W'(1);
    assign last_slot = (idx_inc == count_reg);

    assign in_ch.ready      = (state_reg == ST_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.kind      = out_kind_reg;
    assign out_ch.ok        = out_ok_reg;
    assign out_ch.fired_tag = out_tag_reg;
    assign out_ch.last      = out_last_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_min_reg <= INTERVAL_MIN_RESET;
            interval_max_reg <= INTERVAL_MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INTERVAL_MIN: interval_min_reg <= cfg_wdata;
                CFG_INTERVAL_MAX: interval_max_reg <= cfg_wdata;
                default:          interval_min_reg <= interval_min_reg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            running_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            running_reg    <= running_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg          <= idx_next;
        n_reg            <= n_next;
        pend_tag_reg     <= pend_tag_next;
        ok_reg           <= ok_next;
        cmd_func_reg     <= cmd_func_next;
        cmd_tag_reg      <= cmd_tag_next;
        cmd_interval_reg <= cmd_interval_next;
        cmd_en_reg       <= cmd_en_next;
        cmd_now_reg      <= cmd_now_next;
        out_kind_reg     <= out_kind_next;
        out_ok_reg       <= out_ok_next;
        out_tag_reg      <= out_tag_next;
        out_last_reg     <= out_last_next;
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        count_next        = count_reg;
        running_next      = running_reg;
        n_next            = n_reg;
        pend_valid_next   = pend_valid_reg;
        pend_tag_next     = pend_tag_reg;
        ok_next           = ok_reg;
        cmd_func_next     = cmd_func_reg;
        cmd_tag_next      = cmd_tag_reg;
        cmd_interval_next = cmd_interval_reg;
        cmd_en_next       = cmd_en_reg;
        cmd_now_next      = cmd_now_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        out_kind_next     = out_kind_reg;
        out_ok_next       = out_ok_reg;
        out_tag_next      = out_tag_reg;
        out_last_next     = out_last_reg;
        wr_en             = 1'b0;
        wr_addr           = idx_reg;
        wr_entry          = rd_entry;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    cmd_func_next     = func_t'(in_ch.func);
                    cmd_tag_next      = in_ch.tag;
                    cmd_interval_next = in_ch.interval;
                    cmd_en_next       = in_ch.enable_at_attach;
                    cmd_now_next      = in_ch.now;
                    idx_next          = '0;
                    n_next            = '0;
                    pend_valid_next   = 1'b0;
                    ok_next           = 1'b0;
                    unique case (func_t'(in_ch.func))
                        FUNC_ATTACH:
                        begin
                            state_next = (count_reg == '0) ? ST_ADD : ST_RD;
                        end
                        FUNC_START:
                        begin
                            running_next = 1'b1;
                            ok_next      = 1'b1;
                            state_next   = (count_reg == '0) ? ST_REPLY : ST_RD;
                        end
                        FUNC_STOP:
                        begin
                            running_next = 1'b0;
                            ok_next      = 1'b1;
                            state_next   = ST_REPLY;
                        end
                        FUNC_ENABLE, FUNC_DISABLE:
                        begin
                            state_next = (count_reg == '0) ? ST_REPLY : ST_RD;
                        end
                        FUNC_TICK:
                        begin
                            state_next = (!running_reg || count_reg == '0) ? ST_FLUSH : ST_RD;
                        end
                        default:
                        begin
                            state_next = ST_REPLY;
                        end
                    endcase
                end
            end

            // read data for idx_reg arrives at the end of this cycle
            ST_RD:
            begin
                state_next = ST_EX;
            end

            ST_EX:
            begin
                unique case (cmd_func_reg)
                    FUNC_START:
                    begin
                        wr_en          = 1'b1;
                        wr_entry.stamp = cmd_now_reg;
                        if (last_slot)
                        begin
                            state_next = ST_REPLY;
                        end
                        else
                        begin
                            idx_next   = idx_inc[IDX_W-1:0];
                            state_next = ST_RD;
                        end
                    end
                    FUNC_TICK:
                    begin
                        if (rd_entry.enabled && ures.due && n_reg < N_W'(MAX_RESULTS))
                        begin
                            // an earlier fired word must leave before this one is held
                            if (!pend_valid_reg || out_free)
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_valid_next = 1'b1;
                                    out_kind_next  = KIND_FIRED;
                                    out_ok_next    = 1'b1;
                                    out_tag_next   = pend_tag_reg;
                                    out_last_next  = 1'b0;
                                end
                                wr_en           = 1'b1;
                                wr_entry.stamp  = cmd_now_reg;
                                pend_valid_next = 1'b1;
                                pend_tag_next   = rd_entry.tag;
                                n_next          = n_reg + N_W'(1);
                                if (last_slot)
                                begin
                                    state_next = ST_FLUSH;
                                end
                                else
                                begin
                                    idx_next   = idx_inc[IDX_W-1:0];
                                    state_next = ST_RD;
                                end
                            end
                        end
                        else if (last_slot)
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            idx_next   = idx_inc[IDX_W-1:0];
                            state_next = ST_RD;
                        end
                    end
                    default:
                    begin
                        // tag search for attach, enable and disable
                        if (ures.tag_hit)
                        begin
                            state_next = ST_REPLY;
                            if (cmd_func_reg == FUNC_ENABLE)
                            begin
                                wr_en            = 1'b1;
                                wr_entry.stamp   = cmd_now_reg;
                                wr_entry.enabled = 1'b1;
                                ok_next          = 1'b1;
                            end
                            else if (cmd_func_reg == FUNC_DISABLE)
                            begin
                                wr_en            = 1'b1;
                                wr_entry.enabled = 1'b0;
                                ok_next          = 1'b1;
                            end
                        end
                        else if (last_slot)
                        begin
                            state_next = (cmd_func_reg == FUNC_ATTACH) ? ST_ADD : ST_REPLY;
                        end
                        else
                        begin
                            idx_next   = idx_inc[IDX_W-1:0];
                            state_next = ST_RD;
                        end
                    end
                endcase
            end

            // new slot at the end of the table
            ST_ADD:
            begin
                state_next = ST_REPLY;
                if (ures.bounds_ok && count_reg < CNT_W'(TABLE_DEPTH))
                begin
                    wr_en             = 1'b1;
                    wr_addr           = count_reg[IDX_W-1:0];
                    wr_entry.tag      = cmd_tag_reg;
                    wr_entry.interval = cmd_interval_reg;
                    wr_entry.stamp    = cmd_now_reg;
                    wr_entry.enabled  = cmd_en_reg;
                    count_next        = count_reg + CNT_W'(1);
                    ok_next           = 1'b1;
                end
            end

            ST_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_REPLY;
                    out_ok_next    = ok_reg;
                    out_tag_next   = cmd_tag_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            // final fired word of a tick, if any
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_FIRED;
                    out_ok_next     = 1'b1;
                    out_tag_next    = pend_tag_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/ptt_checker.sv]
module ptt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        out_kind,
    input logic                        out_ok,
    input logic [ptt_pkg::TAG_W-1:0]   out_tag,
    input logic                        out_last
);
    import ptt_pkg::*;

    // a stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_tag) && $stable(out_last)
            && $stable(out_kind) && $stable(out_ok))
    else $error("output word changed while stalled");

    // a reply is always the only word of its command
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_REPLY |-> out_last)
    else $error("reply word without last");

    // fired words always report success
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_FIRED |-> out_ok)
    else $error("fired word with ok low");

    // the sequencer is busy right after taking a command
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("ready again right after accept");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.kind),
    .out_ok    (out_ch.ok),
    .out_tag   (out_ch.fired_tag),
    .out_last  (out_ch.last)
);
